@@ rtl/integer_to_ascii_formatter_core_defines.svh @@
// assertion helpers for the formatter core
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define I2A_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("i2a assertion failed");

// next-cycle implication, checked out of reset
`define I2A_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("i2a assertion failed");

`endif

@@ rtl/i2a_pkg.sv @@
`default_nettype none
package i2a_pkg;

	localparam int VALUE_WIDTH = 64;
	// decimal digits needed for VALUE_WIDTH bits: floor(w * log10(2)) + 1
	localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int DBUF_W = NDIG * 4;
	localparam int NDIG_W = $clog2(NDIG + 1);
	localparam int BITCNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [1:0] CMD_SIGNED = 2'd0;
	localparam logic [1:0] CMD_UNSIGNED = 2'd1;
	localparam logic [1:0] CMD_HEX = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam logic [6:0] CHAR_MINUS = 7'h2D;
	localparam logic [6:0] CHAR_ZERO = 7'h30;
	localparam logic [6:0] CHAR_LOWER_A = 7'h61;
	localparam logic [6:0] CHAR_UPPER_A = 7'h41;

	localparam logic REG_HEX_UPPER = 1'b0;

	typedef struct packed {
		logic [1:0] cmd;
		logic [63:0] value;
		logic [15:0] start_count;
	} num_item_t;

	typedef struct packed {
		logic [6:0] ascii_char;
		logic last;
		logic [15:0] total_count;
	} chr_item_t;

	// status from the serial bcd unit
	typedef struct packed {
		logic busy;
		logic done;
	} bcd_stat_t;

	function automatic logic [6:0] digit_char(input logic [3:0] nib, input logic upper);
		logic [6:0] base;
		begin
			base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
			if (nib < 4'd10) begin
				digit_char = CHAR_ZERO + {3'b000, nib};
			end else begin
				digit_char = base + {3'b000, nib - 4'd10};
			end
		end
	endfunction

	function automatic logic [15:0] count_bump(input logic [15:0] cnt);
		begin
			count_bump = (cnt == COUNT_MAX) ? COUNT_MAX : cnt + 16'd1;
		end
	endfunction

endpackage
`default_nettype wire

@@ rtl/i2a_num_if.sv @@
`default_nettype none
interface i2a_num_if import i2a_pkg::*; ();
	logic valid;
	logic ready;
	num_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/i2a_chr_if.sv @@
`default_nettype none
interface i2a_chr_if import i2a_pkg::*; ();
	logic valid;
	logic ready;
	chr_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/i2a_bcd.sv @@
`default_nettype none
// bit-serial binary to bcd (shift and add 3), one input bit per cycle
module i2a_bcd import i2a_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [VALUE_WIDTH-1:0] bin,
	output bcd_stat_t stat,
	output logic [DBUF_W-1:0] bcd
);

	logic [VALUE_WIDTH-1:0] shreg_q;
	logic [DBUF_W-1:0] bcd_q;
	logic [BITCNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DBUF_W-1:0] adj;

	// digits >= 5 get 3 added before the shift
	always_comb begin
		for (int d = 0; d < NDIG; d++) begin
			adj[d*4 +: 4] = (bcd_q[d*4 +: 4] >= 4'd5) ? bcd_q[d*4 +: 4] + 4'd3
				: bcd_q[d*4 +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == BITCNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= BITCNT_W'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == BITCNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shreg_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			shreg_q <= {shreg_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= {adj[DBUF_W-2:0], shreg_q[VALUE_WIDTH-1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign bcd = bcd_q;

endmodule
`default_nettype wire

@@ rtl/integer_to_ascii_formatter_core.sv @@
// integer to ascii formatter
// num channel (sink): one item carries cmd, value and start_count; cmd selects
//   signed decimal, unsigned decimal or hex, the unused code is taken and dropped
// chars channel (source): one item per character, most significant digit first,
//   a leading minus for negative signed values, last set on the final digit,
//   total_count is start_count plus characters so far, saturating at 65535
// apb port: register 0 (byte address 0) bit 0 is hex_upper, picks A-F over a-f
// decimal passes through the bit-serial bcd unit (VALUE_WIDTH shifts and a
//   done strobe), then a pass drops the leading zero digits (up to 19), then
//   the characters go out in turn, held while the receiver stalls; hex skips
//   the bcd unit and runs the same leading zero pass over the 20-digit buffer
// one number is worked at a time: num.ready is high only while idle
// the last character sits in the output register while the next number is
//   already taken; a stalled receiver freezes character emission in place
// reset clears hex_upper, the state and the output valid
`default_nettype none
`include "integer_to_ascii_formatter_core_defines.svh"
module integer_to_ascii_formatter_core import i2a_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	i2a_num_if.sink num,
	i2a_chr_if.source chars,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ADDR_W-1:0] paddr,
	input wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SKIP = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic hex_upper_q;
	logic neg_q;
	logic [15:0] count_q;
	logic [NDIG_W-1:0] ndig_q;
	logic [DBUF_W-1:0] dig_q;
	logic ovalid_q;
	chr_item_t odata_q;

	logic take;
	logic adv;
	logic [VALUE_WIDTH-1:0] raw;
	logic is_neg;
	logic [VALUE_WIDTH-1:0] mag;
	logic [3:0] top_nib;
	logic bcd_start;
	bcd_stat_t bcd_stat;
	logic [DBUF_W-1:0] bcd_digits;

	// register port, one register at word 0
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_HEX_UPPER) begin
			prdata[0] = hex_upper_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_upper_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_HEX_UPPER) begin
			hex_upper_q <= pwdata[0];
		end
	end

	// input side: magnitude of the masked value
	assign num.ready = (state_q == ST_IDLE);
	assign take = num.valid && num.ready;
	assign raw = num.data.value[VALUE_WIDTH-1:0];
	assign is_neg = (num.data.cmd == CMD_SIGNED) && raw[VALUE_WIDTH-1];
	assign mag = is_neg ? (~raw + 1'b1) : raw;
	assign bcd_start = take && (num.data.cmd == CMD_SIGNED || num.data.cmd == CMD_UNSIGNED);

	i2a_bcd u_bcd (
		.clk(clk),
		.arst_n(arst_n),
		.start(bcd_start),
		.bin(mag),
		.stat(bcd_stat),
		.bcd(bcd_digits)
	);

	// output register moves when empty or being taken
	assign adv = !ovalid_q || chars.ready;
	assign top_nib = dig_q[DBUF_W-1 -: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && adv) begin
				ovalid_q <= 1'b1;
			end else if (chars.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						unique case (num.data.cmd)
							CMD_SIGNED, CMD_UNSIGNED: state_q <= ST_CONV;
							CMD_HEX: state_q <= ST_SKIP;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CONV: begin
					if (bcd_stat.done) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					// stop at the first nonzero digit, or keep a lone zero
					if (top_nib != 4'd0 || ndig_q == NDIG_W'(1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (adv && !neg_q && ndig_q == NDIG_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					neg_q <= is_neg;
					count_q <= num.data.start_count;
					ndig_q <= NDIG_W'(NDIG);
					dig_q <= {{(DBUF_W-VALUE_WIDTH){1'b0}}, mag};
				end
			end
			ST_CONV: begin
				if (bcd_stat.done) begin
					dig_q <= bcd_digits;
				end
			end
			ST_SKIP: begin
				if (top_nib == 4'd0 && ndig_q != NDIG_W'(1)) begin
					dig_q <= {dig_q[DBUF_W-5:0], 4'h0};
					ndig_q <= ndig_q - 1'b1;
				end
			end
			ST_EMIT: begin
				if (adv) begin
					count_q <= count_bump(count_q);
					odata_q.total_count <= count_bump(count_q);
					if (neg_q) begin
						// sign goes out ahead of the digits
						neg_q <= 1'b0;
						odata_q.ascii_char <= CHAR_MINUS;
						odata_q.last <= 1'b0;
					end else begin
						odata_q.ascii_char <= digit_char(top_nib, hex_upper_q);
						odata_q.last <= (ndig_q == NDIG_W'(1));
						dig_q <= {dig_q[DBUF_W-5:0], 4'h0};
						ndig_q <= ndig_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign chars.valid = ovalid_q;
	assign chars.data = odata_q;

	// digit count never runs out while digits are pending
	`I2A_ASSERT_NOW(a_ndig_live, clk, arst_n, (state_q == ST_SKIP || state_q == ST_EMIT), (ndig_q != '0))
	// the final digit sends the sequencer back to idle
	`I2A_ASSERT_NEXT(a_last_idle, clk, arst_n, (state_q == ST_EMIT && adv && !neg_q && ndig_q == NDIG_W'(1)), (state_q == ST_IDLE && ovalid_q && chars.data.last))
	// the bcd unit reports done only on leaving conversion
	`I2A_ASSERT_NOW(a_done_in_conv, clk, arst_n, bcd_stat.done, (state_q == ST_CONV && !bcd_stat.busy))

endmodule
`default_nettype wire
